[src/snc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_pkg: shared types and constants for the needle capture block
// Register codes, sizes, the front-to-back command beat and the config bundle.
// ----------------------------------------------------------------------------
package snc_pkg;

  // Sizes
  localparam int MaxNeedle = 32;                      // window depth of the matcher
  localparam int RegBytes  = 32;                      // needle bytes held in registers
  localparam int LenMax    = (MaxNeedle < RegBytes) ? MaxNeedle : RegBytes;
  localparam int WinDepth  = LenMax;                  // only the first LenMax taps compare
  localparam int LenW      = 6;                       // needle_length field width
  localparam int FillW     = $clog2(WinDepth + 1);
  localparam int NbIdxW    = $clog2(RegBytes);
  localparam int NeedleW   = RegBytes * 8;
  localparam int CntW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  // Command queue
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register reset values
  localparam logic [CntW-1:0] KeepDefault = 16'd128;
  localparam logic [CntW-1:0] BodyDefault = 16'd12288;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgNeedle0   = 3'd0,
    CfgNeedle1   = 3'd1,
    CfgNeedle2   = 3'd2,
    CfgNeedle3   = 3'd3,
    CfgNeedleLen = 3'd4,
    CfgKeep      = 3'd5,
    CfgBody      = 3'd6
  } cfg_reg_t;

  // What the back end must produce for one accepted byte
  typedef enum logic [1:0] {
    CmdByte     = 2'd0,
    CmdOverflow = 2'd1,
    CmdNeedle   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
  } cmd_t;

  // Decoded configuration seen by front and back
  typedef struct packed {
    logic [NeedleW-1:0] needle;
    logic [LenW-1:0]    eff_len;
    logic [CntW-1:0]    keep;
    logic [CntW-1:0]    body;
  } cfg_t;

  function automatic logic [7:0] needle_byte(logic [NeedleW-1:0] nb,
                                             logic [NbIdxW-1:0]  idx);
    return nb[idx*8 +: 8];
  endfunction

endpackage

[src/snc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_front: byte intake and classification
// Keeps the match window and capture counters, and turns each body byte into
// at most one command for the back end.
// ----------------------------------------------------------------------------
module snc_front (
  input  logic          clk,
  input  logic          rst,
  input  snc_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          first_of_body,
  output snc_pkg::cmd_t cmd,
  output logic          cmd_push
);
  import snc_pkg::*;

  logic [7:0]       window [WinDepth];
  logic [7:0]       win_new [WinDepth];
  logic [FillW-1:0] fill, fill_next, cur_fill;
  logic             match_found, match_next, cur_match;
  logic [CntW-1:0]  captured_count, cnt_next, cur_cnt;
  logic             shift_en;
  logic             hit;
  logic             have_cmd;

  // Body start clears the per-body state ahead of this byte
  assign cur_fill  = first_of_body ? '0 : fill;
  assign cur_match = first_of_body ? 1'b0 : match_found;
  assign cur_cnt   = first_of_body ? '0 : captured_count;

  // Window after this byte shifts in
  always_comb begin
    win_new[0] = data_byte;
    for (int j = 1; j < WinDepth; j++) win_new[j] = window[j-1];
  end

  // Compare the newest eff_len taps against the needle, newest tap = last byte
  always_comb begin
    logic [LenW-1:0] nidx;
    hit = 1'b1;
    for (int j = 0; j < WinDepth; j++) begin
      nidx = cfg.eff_len - LenW'(j + 1);
      if ((LenW'(j) < cfg.eff_len) &&
          (win_new[j] != needle_byte(cfg.needle, nidx[NbIdxW-1:0])))
        hit = 1'b0;
    end
  end

  // Classification
  always_comb begin
    fill_next  = cur_fill;
    match_next = cur_match;
    cnt_next   = cur_cnt;
    shift_en   = 1'b0;
    have_cmd   = 1'b0;
    cmd.kind   = CmdByte;
    cmd.data   = data_byte;
    cmd.len    = cfg.eff_len;
    if (cfg.eff_len == '0) begin
      // whole-body capture
      have_cmd = 1'b1;
      if (cur_cnt < cfg.body) begin
        cnt_next = cur_cnt + 16'd1;
      end else begin
        cmd.kind = CmdOverflow;
      end
    end else if (cur_match) begin
      // tail after the match
      if (cur_cnt < cfg.keep) begin
        have_cmd = 1'b1;
        cnt_next = cur_cnt + 16'd1;
      end
    end else begin
      // searching
      shift_en = 1'b1;
      if (cur_fill < FillW'(WinDepth)) fill_next = cur_fill + FillW'(1);
      if ((fill_next >= cfg.eff_len) && hit) begin
        have_cmd   = 1'b1;
        match_next = 1'b1;
        cnt_next   = CntW'(cfg.eff_len);
        cmd.kind   = CmdNeedle;
      end
    end
  end

  assign cmd_push = accept && have_cmd;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      match_found    <= 1'b0;
      captured_count <= '0;
    end else if (accept) begin
      fill           <= fill_next;
      match_found    <= match_next;
      captured_count <= cnt_next;
    end
  end

  // Window taps
  always_ff @(posedge clk) begin
    if (accept && shift_en) begin
      for (int j = 0; j < WinDepth; j++) window[j] <= win_new[j];
    end
  end

endmodule

[src/snc_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_cmd_fifo: command queue between front and back
// Small register queue so intake keeps running while a needle run drains.
// ----------------------------------------------------------------------------
module snc_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  snc_pkg::cmd_t wr_cmd,
  input  logic          rd,
  output snc_pkg::cmd_t head,
  output logic          full,
  output logic          q_empty
);
  import snc_pkg::*;

  cmd_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full    = (count == QCntW'(QDepth));
  assign q_empty = (count == '0);
  assign head    = slots[rd_ptr];

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPtrW'(1);
      if (rd) rd_ptr <= rd_ptr + QPtrW'(1);
      if (wr && !rd)      count <= count + QCntW'(1);
      else if (rd && !wr) count <= count - QCntW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_cmd;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("command queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(rd && q_empty))
    else $error("command queue read while empty");

endmodule

[src/snc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_back: result beat generator
// Expands queued commands into result beats, one per cycle while the output
// register is empty or popped, into the output register.
// ----------------------------------------------------------------------------
module snc_back (
  input  logic          clk,
  input  logic          rst,
  input  snc_pkg::cfg_t cfg,
  input  snc_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          from_needle,
  output logic          overflow_flag,
  output logic          last_of_run
);
  import snc_pkg::*;

  logic            out_valid;
  logic [LenW-1:0] run_idx;
  logic            load;
  logic            done;
  logic [7:0]      b_byte;
  logic            b_valid, b_needle, b_ovf, b_last;

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && done;

  // Beat for the head command
  always_comb begin
    b_byte   = '0;
    b_valid  = 1'b0;
    b_needle = 1'b0;
    b_ovf    = 1'b0;
    b_last   = 1'b1;
    done     = 1'b1;
    unique case (head.kind)
      CmdByte: begin
        b_byte  = head.data;
        b_valid = 1'b1;
      end
      CmdOverflow: begin
        b_ovf = 1'b1;
      end
      CmdNeedle: begin
        b_byte   = needle_byte(cfg.needle, run_idx[NbIdxW-1:0]);
        b_valid  = 1'b1;
        b_needle = 1'b1;
        b_last   = ((run_idx + LenW'(1)) == head.len);
        done     = b_last;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Run position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      run_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        run_idx   <= done ? '0 : run_idx + LenW'(1);
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= b_byte;
      byte_valid    <= b_valid;
      from_needle   <= b_needle;
      overflow_flag <= b_ovf;
      last_of_run   <= b_last;
    end
  end

  a_run_in_needle: assert property (@(posedge clk) disable iff (rst)
    (run_idx != '0) |-> (!q_empty && head.kind == CmdNeedle && run_idx < head.len))
    else $error("needle run position outside a needle command");

endmodule

[src/stream_needle_capture_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_needle_capture_top: streaming needle search with capture window
// Takes one body byte per cycle unless full, finds the configured needle, and
// captures its copy plus the bytes after it, or the whole body if none is set.
// ----------------------------------------------------------------------------
// One body byte is accepted per cycle while the queue is not full. Each byte
// gives at most one command to a four-entry command queue; a match gives a
// needle run that leaves the result port at one beat per cycle while the
// consumer pops, so a match of length N gives N beats; intake goes on until
// the queue fills. The needle compare over the window is done in the cycle the
// byte is taken. Configuration is written on its own always-ready valid/ready
// channel; the user must do so only while no beat is in flight (not enforced).
module stream_needle_capture_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       data_byte,
  input  logic                             first_of_body,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_byte,
  output logic                             byte_valid,
  output logic                             from_needle,
  output logic                             overflow_flag,
  output logic                             last_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [snc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [snc_pkg::CfgDataW-1:0]     cfg_data
);
  import snc_pkg::*;

  logic [NeedleW-1:0] needle;
  logic [LenW-1:0]    needle_length;
  logic [CntW-1:0]    keep_limit;
  logic [CntW-1:0]    body_limit;
  cfg_t               cfg;
  cmd_t               cmd, head;
  logic               accept, cmd_push, q_pop, q_empty;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      needle        <= '0;
      needle_length <= '0;
      keep_limit    <= KeepDefault;
      body_limit    <= BodyDefault;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgNeedle0:   needle[0*CfgDataW +: CfgDataW] <= cfg_data;
        CfgNeedle1:   needle[1*CfgDataW +: CfgDataW] <= cfg_data;
        CfgNeedle2:   needle[2*CfgDataW +: CfgDataW] <= cfg_data;
        CfgNeedle3:   needle[3*CfgDataW +: CfgDataW] <= cfg_data;
        CfgNeedleLen: needle_length <= cfg_data[LenW-1:0];
        CfgKeep:      keep_limit    <= cfg_data[CntW-1:0];
        CfgBody:      body_limit    <= cfg_data[CntW-1:0];
        default:      ;
      endcase
    end
  end

  // Decoded config: clamp needle length, zero keep means the default
  always_comb begin
    cfg.needle  = needle;
    cfg.eff_len = (needle_length > LenW'(LenMax)) ? LenW'(LenMax) : needle_length;
    cfg.keep    = (keep_limit == '0) ? KeepDefault : keep_limit;
    cfg.body    = body_limit;
  end

  snc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .data_byte     (data_byte),
    .first_of_body (first_of_body),
    .cmd           (cmd),
    .cmd_push      (cmd_push)
  );

  snc_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_cmd  (cmd),
    .rd      (q_pop),
    .head    (head),
    .full    (full),
    .q_empty (q_empty)
  );

  snc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .from_needle   (from_needle),
    .overflow_flag (overflow_flag),
    .last_of_run   (last_of_run)
  );

endmodule
